// File: design/cld_pkg.sv
`default_nettype none

package cld_pkg;

    localparam int BUFFER_DEPTH = 128;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);

    localparam logic [2:0] KIND_ECHO     = 3'd0;
    localparam logic [2:0] KIND_READ     = 3'd1;
    localparam logic [2:0] KIND_NOTREADY = 3'd2;
    localparam logic [2:0] KIND_FULL     = 3'd3;
    localparam logic [2:0] KIND_NONE     = 3'd4;

    localparam logic [7:0] CHAR_BS      = 8'd8;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_CARET   = 8'h5E;
    localparam logic [7:0] CHAR_DEL     = 8'd127;
    localparam logic [7:0] CHAR_HIGH    = 8'd128;
    localparam logic [7:0] CTRL_OFFSET  = 8'd64;
    localparam logic [7:0] COUNT_MAX    = 8'd255;
    localparam logic [7:0] PENDING_CTRL = 8'd253;

    typedef enum logic [2:0] {
        OP_PRINT,
        OP_BACKSPACE,
        OP_RETURN,
        OP_CONTROL,
        OP_IGNORE,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] key;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PUSH2,
        B_READ,
        B_EMIT
    } back_state_t;

endpackage

`default_nettype wire

// File: design/console_line_discipline.sv
// An item passes the two-entry front queue, the back-end state B_IDLE, B_PUSH2 for a control
// key or B_READ for a read, and B_EMIT, which loads the output register and waits on m_ready.
// The back end takes a new item only when all results of the last are out; the front queue
// holds up to two. The ring has one write port, so B_PUSH2 writes a control key's second byte.
// Reset clears indices, counts and handshakes and sets echo on; the ring is not cleared.
`default_nettype none

module console_line_discipline
    import cld_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_mode,
    input  wire logic [7:0] s_key_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_kind,
    output logic [7:0]      m_data_byte,
    output logic            m_end_of_line,
    output logic            m_last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);

    logic echo_enable_reg;
    logic echo_enable_next;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    assign cfg_ready        = 1'b1;
    assign echo_enable_next = (cfg_valid && cfg_ready) ? cfg_data : echo_enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_enable_reg <= 1'b1;
        end else begin
            echo_enable_reg <= echo_enable_next;
        end
    end

    cld_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_key_byte (s_key_byte),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    cld_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .echo_enable   (echo_enable_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_end_of_line (m_end_of_line),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

// File: design/cld_front.sv
`default_nettype none

module cld_front
    import cld_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_mode,
    input  wire logic [7:0] s_key_byte,
    output logic            cmd_valid,
    output cmd_t            cmd,
    input  wire logic       cmd_pop
);

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    cmd_t       cls;

    always_comb begin
        cls.key = s_key_byte;
        priority if (s_mode) begin
            cls.op = OP_READ;
        end else if (s_key_byte >= CHAR_HIGH) begin
            cls.op = OP_IGNORE;
        end else if (s_key_byte == CHAR_DEL) begin
            cls.op = OP_BACKSPACE;
        end else if (s_key_byte == CHAR_CR) begin
            cls.op = OP_RETURN;
        end else if (s_key_byte >= CHAR_SPACE) begin
            cls.op = OP_PRINT;
        end else begin
            cls.op = OP_CONTROL;
        end
    end

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// File: design/cld_back.sv
`default_nettype none

module cld_back
    import cld_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       echo_enable,
    input  wire logic       cmd_valid,
    input  wire cmd_t       cmd,
    output logic            cmd_pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_kind,
    output logic [7:0]      m_data_byte,
    output logic            m_end_of_line,
    output logic            m_last
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [7:0] ring_mem [BUFFER_DEPTH];
    logic [7:0] rdata_reg;

    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]  tail_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [7:0]        pending_reg;
    logic [7:0]        pending_next;
    logic [7:0]        line_reg;
    logic [7:0]        line_next;

    logic [2:0] seq_kind_reg [3];
    logic [2:0] seq_kind_next [3];
    logic [7:0] seq_data_reg [3];
    logic [7:0] seq_data_next [3];
    logic       seq_eol_reg;
    logic       seq_eol_next;
    logic [1:0] res_cnt_reg;
    logic [1:0] res_cnt_next;
    logic [1:0] res_idx_reg;
    logic [1:0] res_idx_next;
    logic [7:0] pend_byte_reg;
    logic [7:0] pend_byte_next;

    logic       m_valid_reg;
    logic       m_valid_next;
    logic [2:0] m_kind_reg;
    logic [7:0] m_data_reg;
    logic       m_eol_reg;
    logic       m_last_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;

    logic             out_free;
    logic             emit_load;
    logic             emit_last;
    logic             ring_full;
    logic             room_lt2;
    logic             read_ready;
    logic             ctrl_ok;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] head_dec;
    logic [IDX_W-1:0] tail_inc;

    assign ring_full  = (fill_reg == FILL_W'(BUFFER_DEPTH));
    assign room_lt2   = (fill_reg > FILL_W'(BUFFER_DEPTH - 2));
    assign read_ready = (line_reg != 8'd0) && (fill_reg != '0);
    assign ctrl_ok    = !room_lt2 && (pending_reg <= PENDING_CTRL);
    assign head_inc   = (head_reg == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec   = (head_reg == '0) ? IDX_W'(BUFFER_DEPTH - 1) : head_reg - 1'b1;
    assign tail_inc   = (tail_reg == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit_load = (state_reg == B_EMIT) && out_free;
    assign emit_last = (res_idx_reg == res_cnt_reg - 2'd1);
    assign cmd_pop   = (state_reg == B_IDLE) && cmd_valid;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.op == OP_READ && read_ready) begin
                        state_next = B_READ;
                    end else if (cmd.op == OP_CONTROL && ctrl_ok) begin
                        state_next = B_PUSH2;
                    end else begin
                        state_next = B_EMIT;
                    end
                end
            end
            B_PUSH2: state_next = B_EMIT;
            B_READ:  state_next = B_EMIT;
            B_EMIT: begin
                if (out_free && emit_last) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        pending_next   = pending_reg;
        line_next      = line_reg;
        seq_kind_next  = seq_kind_reg;
        seq_data_next  = seq_data_reg;
        seq_eol_next   = seq_eol_reg;
        res_cnt_next   = res_cnt_reg;
        res_idx_next   = res_idx_reg;
        pend_byte_next = pend_byte_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = cmd.key;
        ram_re         = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    res_idx_next     = 2'd0;
                    res_cnt_next     = 2'd1;
                    seq_eol_next     = 1'b0;
                    seq_kind_next[0] = KIND_NONE;
                    seq_data_next[0] = 8'd0;
                    unique case (cmd.op)
                        OP_IGNORE: begin
                        end
                        OP_BACKSPACE: begin
                            if (pending_reg != 8'd0) begin
                                head_next    = head_dec;
                                fill_next    = fill_reg - 1'b1;
                                pending_next = pending_reg - 8'd1;
                            end
                            if (echo_enable) begin
                                res_cnt_next     = 2'd3;
                                seq_kind_next[0] = KIND_ECHO;
                                seq_data_next[0] = CHAR_BS;
                                seq_kind_next[1] = KIND_ECHO;
                                seq_data_next[1] = CHAR_SPACE;
                                seq_kind_next[2] = KIND_ECHO;
                                seq_data_next[2] = CHAR_BS;
                            end
                        end
                        OP_RETURN: begin
                            if (ring_full || line_reg == COUNT_MAX) begin
                                seq_kind_next[0] = KIND_FULL;
                            end else begin
                                ram_we       = 1'b1;
                                ram_wdata    = CHAR_CR;
                                head_next    = head_inc;
                                fill_next    = fill_reg + 1'b1;
                                line_next    = line_reg + 8'd1;
                                pending_next = 8'd0;
                                if (echo_enable) begin
                                    seq_kind_next[0] = KIND_ECHO;
                                    seq_data_next[0] = CHAR_LF;
                                end
                            end
                        end
                        OP_PRINT: begin
                            if (ring_full || pending_reg == COUNT_MAX) begin
                                seq_kind_next[0] = KIND_FULL;
                            end else begin
                                ram_we       = 1'b1;
                                head_next    = head_inc;
                                fill_next    = fill_reg + 1'b1;
                                pending_next = pending_reg + 8'd1;
                                if (echo_enable) begin
                                    seq_kind_next[0] = KIND_ECHO;
                                    seq_data_next[0] = cmd.key;
                                end
                            end
                        end
                        OP_CONTROL: begin
                            if (!ctrl_ok) begin
                                seq_kind_next[0] = KIND_FULL;
                            end else begin
                                ram_we         = 1'b1;
                                ram_wdata      = CHAR_CARET;
                                head_next      = head_inc;
                                fill_next      = fill_reg + 1'b1;
                                pending_next   = pending_reg + 8'd2;
                                pend_byte_next = cmd.key + CTRL_OFFSET;
                                if (echo_enable) begin
                                    res_cnt_next     = 2'd2;
                                    seq_kind_next[0] = KIND_ECHO;
                                    seq_data_next[0] = CHAR_CARET;
                                    seq_kind_next[1] = KIND_ECHO;
                                    seq_data_next[1] = cmd.key + CTRL_OFFSET;
                                end
                            end
                        end
                        OP_READ: begin
                            if (read_ready) begin
                                ram_re    = 1'b1;
                                tail_next = tail_inc;
                                fill_next = fill_reg - 1'b1;
                            end else begin
                                seq_kind_next[0] = KIND_NOTREADY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_PUSH2: begin
                ram_we    = 1'b1;
                ram_wdata = pend_byte_reg;
                head_next = head_inc;
                fill_next = fill_reg + 1'b1;
            end
            B_READ: begin
                seq_kind_next[0] = KIND_READ;
                seq_data_next[0] = rdata_reg;
                seq_eol_next     = (rdata_reg == CHAR_CR);
                if (rdata_reg == CHAR_CR) begin
                    line_next = line_reg - 8'd1;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    res_idx_next = res_idx_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (emit_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            pending_reg <= 8'd0;
            line_reg    <= 8'd0;
            res_cnt_reg <= 2'd1;
            res_idx_reg <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            pending_reg <= pending_next;
            line_reg    <= line_next;
            res_cnt_reg <= res_cnt_next;
            res_idx_reg <= res_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_kind_reg  <= seq_kind_next;
        seq_data_reg  <= seq_data_next;
        seq_eol_reg   <= seq_eol_next;
        pend_byte_reg <= pend_byte_next;
        if (emit_load) begin
            m_kind_reg <= seq_kind_reg[res_idx_reg];
            m_data_reg <= seq_data_reg[res_idx_reg];
            m_eol_reg  <= (res_idx_reg == 2'd0) ? seq_eol_reg : 1'b0;
            m_last_reg <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ring_mem[ram_waddr] <= ram_wdata;
        end
        if (ram_re) begin
            rdata_reg <= ring_mem[tail_reg];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_data_byte   = m_data_reg;
    assign m_end_of_line = m_eol_reg;
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;
    import cld_pkg::*;

    localparam logic MODE_KEY   = 1'b0;
    localparam logic MODE_READ  = 1'b1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEMS_RANDOM = 24;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_style_t;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] data;
        logic       eol;
        logic       last;
    } reply_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_mode     = 1'b0;
    logic [7:0] s_key_byte = 8'd0;
    logic       m_ready    = 1'b0;
    logic       cfg_valid  = 1'b0;
    logic       cfg_data   = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire  [2:0] m_kind;
    wire  [7:0] m_data_byte;
    wire        m_end_of_line;
    wire        m_last;
    wire        cfg_ready;

    console_line_discipline u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_key_byte    (s_key_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_end_of_line (m_end_of_line),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Shadow of the console state, updated as each item is accepted.
    logic [7:0] ring [BUFFER_DEPTH];
    int         head_idx  = 0;
    int         tail_idx  = 0;
    int         fill_cnt  = 0;
    int         pend_cnt  = 0;
    int         line_cnt  = 0;
    logic       echo_on   = 1'b1;

    reply_t       line_replies [$];
    int           fail_cnt    = 0;
    int           cycle_cnt   = 0;
    int           burst_left  = 0;
    bit           gaps_on     = 1'b1;
    int           cooked_cnt  = 0;
    stall_style_t stall_style = STALL_RANDOM;
    int           stall_phase = 0;
    int           hold_left   = 0;
    bit           hold_req    = 1'b0;

    always #4 aclk = ~aclk;

    task automatic add_reply(input logic [2:0] kind, input logic [7:0] data,
                             input logic eol, input logic last);
        reply_t r;
        r.kind = kind;
        r.data = data;
        r.eol  = eol;
        r.last = last;
        line_replies.push_back(r);
    endtask

    task automatic queue_char(input logic [7:0] b);
        ring[head_idx] = b;
        head_idx = (head_idx + 1) % BUFFER_DEPTH;
        fill_cnt++;
    endtask

    task automatic cook_item(input logic mode, input logic [7:0] key);
        int         room;
        logic [7:0] b;
        room = BUFFER_DEPTH - fill_cnt;
        if (mode == MODE_READ) begin
            if (line_cnt == 0 || fill_cnt == 0) begin
                add_reply(KIND_NOTREADY, 8'd0, 1'b0, 1'b1);
            end else begin
                b = ring[tail_idx];
                tail_idx = (tail_idx + 1) % BUFFER_DEPTH;
                fill_cnt--;
                if (b == CHAR_CR) line_cnt--;
                add_reply(KIND_READ, b, b == CHAR_CR, 1'b1);
            end
        end else if (key >= CHAR_HIGH) begin
            add_reply(KIND_NONE, 8'd0, 1'b0, 1'b1);
        end else if (key == CHAR_DEL) begin
            if (pend_cnt > 0) begin
                head_idx = (head_idx + BUFFER_DEPTH - 1) % BUFFER_DEPTH;
                fill_cnt--;
                pend_cnt--;
            end
            if (!echo_on) begin
                add_reply(KIND_NONE, 8'd0, 1'b0, 1'b1);
            end else begin
                add_reply(KIND_ECHO, CHAR_BS, 1'b0, 1'b0);
                add_reply(KIND_ECHO, CHAR_SPACE, 1'b0, 1'b0);
                add_reply(KIND_ECHO, CHAR_BS, 1'b0, 1'b1);
            end
        end else if (key == CHAR_CR) begin
            if (room < 1 || line_cnt >= COUNT_MAX) begin
                add_reply(KIND_FULL, 8'd0, 1'b0, 1'b1);
            end else begin
                queue_char(CHAR_CR);
                line_cnt++;
                pend_cnt = 0;
                if (echo_on) add_reply(KIND_ECHO, CHAR_LF, 1'b0, 1'b1);
                else add_reply(KIND_NONE, 8'd0, 1'b0, 1'b1);
            end
        end else if (key >= CHAR_SPACE) begin
            if (room < 1 || pend_cnt + 1 > COUNT_MAX) begin
                add_reply(KIND_FULL, 8'd0, 1'b0, 1'b1);
            end else begin
                queue_char(key);
                pend_cnt++;
                if (echo_on) add_reply(KIND_ECHO, key, 1'b0, 1'b1);
                else add_reply(KIND_NONE, 8'd0, 1'b0, 1'b1);
            end
        end else begin
            if (room < 2 || pend_cnt + 2 > COUNT_MAX) begin
                add_reply(KIND_FULL, 8'd0, 1'b0, 1'b1);
            end else begin
                queue_char(CHAR_CARET);
                queue_char(key + CTRL_OFFSET);
                pend_cnt += 2;
                if (!echo_on) begin
                    add_reply(KIND_NONE, 8'd0, 1'b0, 1'b1);
                end else begin
                    add_reply(KIND_ECHO, CHAR_CARET, 1'b0, 1'b0);
                    add_reply(KIND_ECHO, key + CTRL_OFFSET, 1'b0, 1'b1);
                end
            end
        end
    endtask

    task automatic send_item(input logic mode, input logic [7:0] key);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_key_byte <= key;
        do @(posedge aclk); while (!s_ready);
        cook_item(mode, key);
        if (!(mode == MODE_KEY && key >= CHAR_HIGH)) cooked_cnt++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (line_replies.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_echo(input logic on);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= on;
        do @(posedge aclk); while (!cfg_ready);
        echo_on = on;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_lines();
        while (line_cnt > 0) send_item(MODE_READ, 8'd0);
        send_item(MODE_READ, 8'd0);
    endtask

    function automatic logic [7:0] random_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 8'($urandom_range(32, 126));
        if (r < 75) return 8'($urandom_range(0, 31));
        if (r < 92) return CHAR_DEL;
        return 8'($urandom_range(128, 255));
    endfunction

    task automatic test_key_classes();
        send_item(MODE_READ, 8'd0);
        send_item(MODE_KEY, CHAR_DEL);
        send_item(MODE_KEY, "x");
        send_item(MODE_READ, 8'd0);
        send_item(MODE_KEY, CHAR_DEL);
        send_item(MODE_KEY, CHAR_SPACE);
        send_item(MODE_KEY, 8'd126);
        send_item(MODE_KEY, 8'd0);
        send_item(MODE_KEY, 8'd31);
        send_item(MODE_KEY, "A");
        send_item(MODE_KEY, 8'd1);
        send_item(MODE_KEY, CHAR_DEL);
        send_item(MODE_KEY, CHAR_DEL);
        send_item(MODE_KEY, CHAR_CR);
        send_item(MODE_KEY, CHAR_DEL);
        send_item(MODE_KEY, CHAR_HIGH);
        send_item(MODE_KEY, 8'd255);
        drain_lines();
    endtask

    task automatic test_echo_off();
        write_echo(1'b0);
        send_item(MODE_KEY, "a");
        send_item(MODE_KEY, 8'd5);
        send_item(MODE_KEY, "b");
        send_item(MODE_KEY, CHAR_DEL);
        send_item(MODE_KEY, CHAR_CR);
        send_item(MODE_KEY, 8'd200);
        drain_lines();
        write_echo(1'b1);
    endtask

    task automatic test_full_buffer();
        while (fill_cnt < BUFFER_DEPTH - 2) send_item(MODE_KEY, 8'($urandom_range(14, 31)));
        send_item(MODE_KEY, 8'd7);
        send_item(MODE_KEY, "z");
        send_item(MODE_KEY, "y");
        send_item(MODE_KEY, CHAR_CR);
        send_item(MODE_KEY, 8'd2);
        send_item(MODE_KEY, CHAR_DEL);
        send_item(MODE_KEY, CHAR_CR);
        send_item(MODE_READ, 8'd0);
        send_item(MODE_READ, 8'd0);
    endtask

    task automatic test_random_lines();
        int           start;
        int           len;
        stall_style_t styles [4] = '{STALL_RANDOM, STALL_PERIODIC, STALL_NONE, STALL_RANDOM};
        for (int p = 0; p < 4; p++) begin
            write_echo(p == 3 ? logic'($urandom_range(0, 1)) : logic'(p != 1));
            stall_style = styles[p];
            gaps_on = (p != 2);
            start = cooked_cnt;
            while (cooked_cnt - start < ITEMS_RANDOM / 4) begin
                if ($urandom_range(0, 99) < 75) begin
                    len = $urandom_range(0, 6);
                    for (int i = 0; i < len; i++) send_item(MODE_KEY, random_key());
                    send_item(MODE_KEY, CHAR_CR);
                    len = $urandom_range(0, 2 * len + 3);
                    for (int i = 0; i < len; i++) send_item(MODE_READ, 8'd0);
                end else begin
                    len = $urandom_range(1, 4);
                    for (int i = 0; i < len; i++)
                        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
            end
        end
        gaps_on = 1'b1;
        stall_style = STALL_RANDOM;
    endtask

    task automatic test_backpressure();
        write_echo(1'b1);
        gaps_on = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++) send_item(MODE_KEY, 8'($urandom_range(32, 126)));
        send_item(MODE_KEY, CHAR_CR);
        gaps_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (stall_style)
                STALL_NONE: begin
                    m_ready <= 1'b1;
                end
                STALL_PERIODIC: begin
                    m_ready <= (stall_phase % 7) >= 2;
                end
                default: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
        stall_phase++;
    end

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (line_replies.size() == 0) begin
                $error("unexpected result: kind %0d data_byte %0d", m_kind, m_data_byte);
                fail_cnt++;
            end else begin
                want = line_replies.pop_front();
                if (m_kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, m_kind);
                    fail_cnt++;
                end
                if (m_data_byte !== want.data) begin
                    $error("data_byte: expected %0d, actual %0d", want.data, m_data_byte);
                    fail_cnt++;
                end
                if (m_end_of_line !== want.eol) begin
                    $error("end_of_line: expected %0d, actual %0d", want.eol, m_end_of_line);
                    fail_cnt++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_last);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("console_line_discipline: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_key_classes();
        test_echo_off();
        test_random_lines();
        test_backpressure();
        test_full_buffer();
        settle();
        if (fail_cnt == 0 && line_replies.size() == 0) begin
            $display("console_line_discipline: match");
        end else begin
            $display("console_line_discipline: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
design/cld_pkg.sv
design/cld_front.sv
design/cld_back.sv
design/console_line_discipline.sv
test/tb_top.sv
